// ----- design/assert_macros.svh -----
// Assertion macros shared by the segment text scroll window modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define STSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true.
`define STSW_ASSERT_NEVER(lbl, cond, msg) \
  `STSW_ASSERT(lbl, !(cond), msg)

`endif

// ----- design/stsw_pkg.sv -----
// Package for the segment text scroll window: sizes, codes and shared types.
package stsw_pkg;

  // Sizing
  localparam int BUFFER_DEPTH     = 256;
  localparam int MAX_WINDOW_BYTES = 64;
  localparam int BYTES_PER_CHAR   = 2;
  localparam int MAX_DIGITS       = 32;

  localparam int ADDR_W  = $clog2(BUFFER_DEPTH);
  localparam int LEN_W   = $clog2(BUFFER_DEPTH + 1);
  localparam int CNT_W   = $clog2(LEN_W);
  localparam int WIN_W   = $clog2(MAX_WINDOW_BYTES + 1);
  localparam int CMP_W   = ((LEN_W > WIN_W) ? LEN_W : WIN_W) + 1;
  localparam int IDX_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int TICK_W  = 16;
  localparam int DIGIT_W = 6;
  localparam int OP_W    = 2;

  // Config port
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  // Register reset values
  localparam logic [TICK_W-1:0]  START_DELAY_RST   = TICK_W'(1500);
  localparam logic [TICK_W-1:0]  STEP_INTERVAL_RST = TICK_W'(250);
  localparam logic [TICK_W-1:0]  END_DWELL_RST     = TICK_W'(1500);
  localparam logic [DIGIT_W-1:0] DIGIT_COUNT_RST   = DIGIT_W'(4);

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_APPEND = 2'd2,
    OP_COMMIT = 2'd3
  } op_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SCROLL_ENABLE   = 3'd0,
    REG_CONTINUOUS_MODE = 3'd1,
    REG_START_DELAY     = 3'd2,
    REG_STEP_INTERVAL   = 3'd3,
    REG_END_DWELL       = 3'd4,
    REG_DIGIT_COUNT     = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               scroll_enable;
    logic               continuous_mode;
    logic [TICK_W-1:0]  start_delay;
    logic [TICK_W-1:0]  step_interval;
    logic [TICK_W-1:0]  end_dwell;
    logic [DIGIT_W-1:0] digit_count;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic mod_step;
    logic emit_step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_emit;
    logic need_mod;
    logic mod_last;
    logic emit_last;
  } sts_t;

endpackage

// ----- design/stsw_ram.sv -----
// Generic single write port RAM with registered read.
module stsw_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/stsw_regs.sv -----
// APB-style configuration registers of the scroll window.
module stsw_regs
  import stsw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  output logic [PDATA_W-1:0] prdata_o,
  output logic               pready_o,
  output cfg_t               cfg_o
);

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i & pready_o;
  assign reg_idx  = paddr_i[PADDR_W-1:2];

  // Register writes; addresses past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scroll_enable   <= 1'b0;
      cfg_q.continuous_mode <= 1'b0;
      cfg_q.start_delay     <= START_DELAY_RST;
      cfg_q.step_interval   <= STEP_INTERVAL_RST;
      cfg_q.end_dwell       <= END_DWELL_RST;
      cfg_q.digit_count     <= DIGIT_COUNT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SCROLL_ENABLE:   cfg_q.scroll_enable   <= pwdata_i[0];
        REG_CONTINUOUS_MODE: cfg_q.continuous_mode <= pwdata_i[0];
        REG_START_DELAY:     cfg_q.start_delay     <= pwdata_i[TICK_W-1:0];
        REG_STEP_INTERVAL:   cfg_q.step_interval   <= pwdata_i[TICK_W-1:0];
        REG_END_DWELL:       cfg_q.end_dwell       <= pwdata_i[TICK_W-1:0];
        REG_DIGIT_COUNT:     cfg_q.digit_count     <= pwdata_i[DIGIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata_o = '0;
    unique case (reg_idx)
      REG_SCROLL_ENABLE:   prdata_o = PDATA_W'(cfg_q.scroll_enable);
      REG_CONTINUOUS_MODE: prdata_o = PDATA_W'(cfg_q.continuous_mode);
      REG_START_DELAY:     prdata_o = PDATA_W'(cfg_q.start_delay);
      REG_STEP_INTERVAL:   prdata_o = PDATA_W'(cfg_q.step_interval);
      REG_END_DWELL:       prdata_o = PDATA_W'(cfg_q.end_dwell);
      REG_DIGIT_COUNT:     prdata_o = PDATA_W'(cfg_q.digit_count);
      default:             prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/stsw_ctrl.sv -----
// Controller state machine: request accept, wrap remainder and window emit sequencing.
module stsw_ctrl
  import stsw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

`include "assert_macros.svh"

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = start_i;
        if (start_i && sts_i.need_emit) begin
          state_d = sts_i.need_mod ? ST_MOD : ST_EMIT;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_step = 1'b1;
        if (sts_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // A request that shows the window keeps the block busy
  `STSW_ASSERT(a_emit_req_busy, cmd_o.accept && sts_i.need_emit |=> busy_o,
               "window request did not raise busy")
  // The remainder phase always hands over to the emit phase
  `STSW_ASSERT(a_mod_to_emit, state_q == ST_MOD |=> state_q != ST_IDLE,
               "remainder phase returned to idle")

endmodule

// ----- design/stsw_dp.sv -----
// Datapath: text buffer, scroll timing, wrap remainder and window byte output.
module stsw_dp
  import stsw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  output logic              result_valid_o,
  output logic [IDX_W-1:0]  byte_index_o,
  output logic [BYTE_W-1:0] segment_byte_o,
  output logic              last_byte_o
);

`include "assert_macros.svh"

  // Architectural state
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  prev_len_q, prev_len_d;
  logic [LEN_W-1:0]  offset_q, offset_d;
  logic [TICK_W-1:0] elapsed_q, elapsed_d;

  // Emit and remainder engine
  logic [LEN_W-1:0] pos_q;
  logic [IDX_W-1:0] idx_q;
  logic             ended_q;
  logic [LEN_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;

  // Output stage
  logic              out_valid_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_last_q;
  logic              out_hit_q;
  logic [BYTE_W-1:0] ram_rdata;

  // Window size
  logic [DIGIT_W-1:0] digits;
  logic [DIGIT_W:0]   win2;
  logic [WIN_W-1:0]   win_bytes;

  // Request decode
  op_e               op;
  logic [TICK_W-1:0] el_inc;
  logic              fits;
  logic              at_end;
  logic              tick_emit;
  logic              ram_we;

  // Remainder step
  logic [LEN_W:0]   shifted;
  logic [LEN_W:0]   rem_next;

  // Emit step
  logic             pos_ge;
  logic             end_now;
  logic             hit;
  logic [LEN_W-1:0] pos_eff;

  // Window byte count: clamp digits to 1..MAX_DIGITS, two bytes each, capped
  always_comb begin
    if (cfg_i.digit_count == '0) begin
      digits = DIGIT_W'(1);
    end else if (cfg_i.digit_count > DIGIT_W'(MAX_DIGITS)) begin
      digits = DIGIT_W'(MAX_DIGITS);
    end else begin
      digits = cfg_i.digit_count;
    end
    win2 = (DIGIT_W + 1)'(digits) * (DIGIT_W + 1)'(BYTES_PER_CHAR);
    if (win2 > (DIGIT_W + 1)'(MAX_WINDOW_BYTES)) begin
      win_bytes = WIN_W'(MAX_WINDOW_BYTES);
    end else begin
      win_bytes = WIN_W'(win2);
    end
  end

  // Request handling: tick timing, clear, append, commit
  always_comb begin
    op         = op_e'(operation_i);
    len_d      = len_q;
    prev_len_d = prev_len_q;
    offset_d   = offset_q;
    elapsed_d  = elapsed_q;
    tick_emit  = 1'b0;
    ram_we     = 1'b0;
    el_inc     = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
    fits       = CMP_W'(len_q) <= CMP_W'(win_bytes);
    if (cfg_i.continuous_mode) begin
      at_end = offset_q > (len_q - LEN_W'(2));
    end else begin
      at_end = (CMP_W'(offset_q) + CMP_W'(win_bytes)) >= CMP_W'(len_q);
    end

    if (cmd_i.accept) begin
      unique case (op)
        OP_TICK: begin
          elapsed_d = el_inc;
          if (cfg_i.scroll_enable && !fits &&
              !(offset_q == '0 && el_inc < cfg_i.start_delay)) begin
            if (at_end) begin
              if (cfg_i.continuous_mode || el_inc >= cfg_i.end_dwell) begin
                offset_d  = '0;
                elapsed_d = '0;
                tick_emit = 1'b1;
              end
            end else if (el_inc >= cfg_i.step_interval) begin
              offset_d  = offset_q + LEN_W'(BYTES_PER_CHAR);
              elapsed_d = '0;
              tick_emit = 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          len_d = '0;
        end
        OP_APPEND: begin
          if (len_q < LEN_W'(BUFFER_DEPTH)) begin
            ram_we = 1'b1;
            len_d  = len_q + 1'b1;
          end
        end
        OP_COMMIT: begin
          if ((cfg_i.scroll_enable && prev_len_q != len_q && !cfg_i.continuous_mode)
              || fits) begin
            elapsed_d = '0;
            offset_d  = '0;
          end
          prev_len_d = len_q;
        end
        default: ;
      endcase
    end
  end

  // Remainder of offset by length, one quotient bit per cycle
  always_comb begin
    shifted  = {rem_q, offset_q[cnt_q]};
    rem_next = (shifted >= {1'b0, len_q}) ? shifted - {1'b0, len_q} : shifted;
  end

  // Window position: padding past the end, or wrap back to the start
  always_comb begin
    pos_ge  = pos_q >= len_q;
    end_now = !ended_q && pos_ge && (!cfg_i.continuous_mode || len_q == '0);
    hit     = !ended_q && !end_now;
    pos_eff = pos_ge ? '0 : pos_q;
  end

  // Status to controller
  always_comb begin
    sts_o.need_emit = (op == OP_COMMIT) || tick_emit;
    sts_o.need_mod  = cfg_i.continuous_mode && (len_q != '0);
    sts_o.mod_last  = (cnt_q == '0);
    sts_o.emit_last = (WIN_W'(idx_q) == win_bytes - 1'b1);
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      prev_len_q  <= '0;
      offset_q    <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      prev_len_q  <= prev_len_d;
      offset_q    <= offset_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= cmd_i.emit_step;
    end
  end

  // Emit engine and output stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_q   <= offset_d;
      idx_q   <= '0;
      ended_q <= 1'b0;
      rem_q   <= '0;
      cnt_q   <= CNT_W'(LEN_W - 1);
    end else if (cmd_i.mod_step) begin
      rem_q <= rem_next[LEN_W-1:0];
      cnt_q <= cnt_q - 1'b1;
      if (sts_o.mod_last) begin
        pos_q <= rem_next[LEN_W-1:0];
      end
    end else if (cmd_i.emit_step) begin
      pos_q   <= pos_eff + 1'b1;
      idx_q   <= idx_q + 1'b1;
      ended_q <= ended_q | end_now;
    end
    if (cmd_i.emit_step) begin
      out_idx_q  <= idx_q;
      out_last_q <= sts_o.emit_last;
      out_hit_q  <= hit;
    end
  end

  // Text buffer
  stsw_ram #(
    .Width (BYTE_W),
    .Depth (BUFFER_DEPTH)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (len_q[ADDR_W-1:0]),
    .wdata_i (data_byte_i),
    .re_i    (cmd_i.emit_step),
    .raddr_i (pos_eff[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o = out_valid_q;
  assign byte_index_o   = out_idx_q;
  assign last_byte_o    = out_last_q;
  assign segment_byte_o = out_hit_q ? ram_rdata : '0;

  // Window bytes come out back to back, in index order
  `STSW_ASSERT(a_window_contig,
               out_valid_q && !out_last_q |=> out_valid_q &&
               out_idx_q == IDX_W'($past(out_idx_q) + 1'b1),
               "window bytes not contiguous")
  `STSW_ASSERT(a_window_start,
               out_valid_q && out_idx_q != '0 |-> $past(out_valid_q),
               "window started at nonzero index")
  `STSW_ASSERT_NEVER(a_len_bound, len_q > LEN_W'(BUFFER_DEPTH),
                     "text length past buffer depth")

endmodule

// ----- design/segment_text_scroll_window.sv -----
// Top level of the segment text scroll window.
// Clear, append and ticks that do not step leave busy low.
// Commit or scroll step: busy while the W = 2 x digits (max 64) window bytes are emitted, after a serial
// offset-by-length remainder that runs first in continuous mode with non-empty text. Bytes come one per
// cycle via the single RAM read port, through the registered RAM read and the output stage.
// Reset is asynchronous: length, offset, ticks and registers clear; buffer content is kept.
module segment_text_scroll_window
  import stsw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [BYTE_W-1:0]  data_byte_i,
  output logic               result_valid_o,
  output logic [IDX_W-1:0]   byte_index_o,
  output logic [BYTE_W-1:0]  segment_byte_o,
  output logic               last_byte_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers
  stsw_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // Sequencing
  stsw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // Buffer and window datapath
  stsw_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .data_byte_i    (data_byte_i),
    .result_valid_o (result_valid_o),
    .byte_index_o   (byte_index_o),
    .segment_byte_o (segment_byte_o),
    .last_byte_o    (last_byte_o)
  );

endmodule

// ----- verif/tb_segment_text_scroll_window.sv -----
// Self-checking testbench for the segment text scroll window: directed and random requests.
`timescale 1ns / 1ps

module tb_segment_text_scroll_window
  import stsw_pkg::*;
();

  localparam int SETTLE_CYCLES  = 80;    // longest emission incl. wrap remainder, with margin
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake or result
  localparam int MAX_REPORTS    = 100;

  typedef struct packed {
    logic [IDX_W-1:0]  pos;
    logic [BYTE_W-1:0] seg;
    logic              last;
  } win_byte_t;

  // Predicts the emitted window bytes and checks them in order
  class window_checker;
    logic [BYTE_W-1:0] text_mem [BUFFER_DEPTH];
    int unsigned text_len, committed_len, win_pos, tick_count;
    bit          scroll_on, wrap_on;
    int unsigned hold_start, step_gap, hold_end, digits;
    win_byte_t   pending_bytes[$];
    int unsigned errors, bytes_checked;

    function new();
      hold_start = START_DELAY_RST;
      step_gap   = STEP_INTERVAL_RST;
      hold_end   = END_DWELL_RST;
      digits     = DIGIT_COUNT_RST;
    endfunction

    function void set_reg(reg_e r, logic [PDATA_W-1:0] v);
      case (r)
        REG_SCROLL_ENABLE:   scroll_on  = v[0];
        REG_CONTINUOUS_MODE: wrap_on    = v[0];
        REG_START_DELAY:     hold_start = v[TICK_W-1:0];
        REG_STEP_INTERVAL:   step_gap   = v[TICK_W-1:0];
        REG_END_DWELL:       hold_end   = v[TICK_W-1:0];
        REG_DIGIT_COUNT:     digits     = v[DIGIT_W-1:0];
        default: ;
      endcase
    endfunction

    // Visible bytes: digit count clamped to 1..32, two bytes per digit
    function int unsigned width();
      int unsigned d;
      d = digits;
      if (d < 1) d = 1;
      if (d > MAX_DIGITS) d = MAX_DIGITS;
      d = d * BYTES_PER_CHAR;
      if (d > MAX_WINDOW_BYTES) d = MAX_WINDOW_BYTES;
      return d;
    endfunction

    // Queue the whole window starting at the current offset
    function void show_window();
      int unsigned w, p;
      bit          ended;
      logic [BYTE_W-1:0] b;
      win_byte_t   wb;
      w = width();
      p = win_pos;
      ended = 0;
      for (int unsigned i = 0; i < w; i++) begin
        b = '0;
        if (!ended) begin
          if (p >= text_len) begin
            if (!wrap_on || text_len == 0) ended = 1;
            else p = p % text_len;
          end
          if (!ended && p < BUFFER_DEPTH) b = text_mem[p];
        end
        wb.pos  = IDX_W'(i);
        wb.seg  = b;
        wb.last = (i == w - 1);
        pending_bytes = {pending_bytes, wb};
        p++;
      end
    endfunction

    function void advance_tick();
      int unsigned w;
      bit          at_end;
      w = width();
      if (tick_count < 65535) tick_count++;
      if (!scroll_on || text_len <= w) return;
      if (win_pos == 0 && tick_count < hold_start) return;
      if (wrap_on) at_end = win_pos > text_len - 2;
      else at_end = win_pos + w >= text_len;
      if (at_end) begin
        if (wrap_on || tick_count >= hold_end) begin
          win_pos = 0;
          tick_count = 0;
          show_window();
        end
      end else if (tick_count >= step_gap) begin
        win_pos += BYTES_PER_CHAR;
        tick_count = 0;
        show_window();
      end
    endfunction

    function void take_request(op_e op, logic [BYTE_W-1:0] data);
      case (op)
        OP_TICK:  advance_tick();
        OP_CLEAR: text_len = 0;
        OP_APPEND: begin
          // full buffer drops the byte
          if (text_len < BUFFER_DEPTH) begin
            text_mem[text_len] = data;
            text_len++;
          end
        end
        OP_COMMIT: begin
          if ((scroll_on && committed_len != text_len && !wrap_on) || text_len <= width()) begin
            tick_count = 0;
            win_pos = 0;
          end
          committed_len = text_len;
          show_window();
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] seg, logic last);
      win_byte_t exp_b;
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected window byte: index %0d segment 0x%02h last %0b",
                   $time, idx, seg, last);
        return;
      end
      exp_b = pending_bytes.pop_front();
      bytes_checked++;
      if (idx !== exp_b.pos || seg !== exp_b.seg || last !== exp_b.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: window byte mismatch: expected index %0d segment 0x%02h last %0b, %s",
                   $time, exp_b.pos, exp_b.seg, exp_b.last,
                   $sformatf("got index %0d segment 0x%02h last %0b", idx, seg, last));
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    operation_i = OP_TICK;
  logic [BYTE_W-1:0]  data_byte_i = '0;
  logic               result_valid_o;
  logic [IDX_W-1:0]   byte_index_o;
  logic [BYTE_W-1:0]  segment_byte_o;
  logic               last_byte_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  window_checker sb = new();
  int unsigned   idle_pct;
  int unsigned   n_requests;
  int unsigned   n_settings;
  int unsigned   quiet_cycles;

  segment_text_scroll_window dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .data_byte_i    (data_byte_i),
    .result_valid_o (result_valid_o),
    .byte_index_o   (byte_index_o),
    .segment_byte_o (segment_byte_o),
    .last_byte_o    (last_byte_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result monitor: every strobe is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_ni && result_valid_o === 1'b1)
      sb.check_byte(byte_index_o, segment_byte_o, last_byte_o);
  end

  // Watchdog: any request, result or register write restarts the count
  always @(posedge clk) begin
    if ((start && !busy) || result_valid_o || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One request: optional sender gap, then hold start until accepted
  task automatic send_request(op_e op, logic [BYTE_W-1:0] data);
    int unsigned n;
    if ($urandom_range(99) < idle_pct) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
    start       <= 1'b1;
    operation_i <= op;
    data_byte_i <= data;
    do @(posedge clk); while (busy !== 1'b0);
    sb.take_request(op, data);
    n_requests++;
  endtask

  // Drop start and wait until all expected bytes are out and the block is quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup and access cycle, then return to idle
  task automatic write_reg(reg_e r, logic [PDATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({r, 2'b00});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_reg(r, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Full register setting, written while idle; also picks the sender idle rate
  task automatic apply_setting(bit scroll, bit wrap, int unsigned hold0, int unsigned step,
                               int unsigned hold1, int unsigned dig);
    settle();
    write_reg(REG_SCROLL_ENABLE, scroll);
    write_reg(REG_CONTINUOUS_MODE, wrap);
    write_reg(REG_START_DELAY, hold0);
    write_reg(REG_STEP_INTERVAL, step);
    write_reg(REG_END_DWELL, hold1);
    write_reg(REG_DIGIT_COUNT, dig);
    case (n_settings % 3)
      0: idle_pct = 0;
      1: idle_pct = 58;
      default: idle_pct = 10;
    endcase
    n_settings++;
  endtask

  // Mostly clear / fill / commit / tick sequences, some random noise
  task automatic run_random(int unsigned n_items);
    int unsigned target, len, ticks;
    target = n_requests + n_items;
    while (n_requests < target) begin
      if ($urandom_range(9) < 7) begin
        send_request(OP_CLEAR, 8'($urandom));
        len = $urandom_range(0, sb.width() + 10);
        repeat (len) send_request(OP_APPEND, 8'($urandom));
        send_request(OP_COMMIT, 8'($urandom));
        ticks = $urandom_range(0, 30);
        repeat (ticks) send_request(OP_TICK, 8'($urandom));
        // recommit with the same length keeps the scroll position
        if ($urandom_range(1)) send_request(OP_COMMIT, 8'($urandom));
        if ($urandom_range(2) == 0) begin
          repeat ($urandom_range(1, 3)) send_request(OP_APPEND, 8'($urandom));
          send_request(OP_COMMIT, 8'($urandom));
          repeat ($urandom_range(0, 12)) send_request(OP_TICK, 8'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_request(op_e'($urandom_range(0, 3)), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed: reset setting, scrolling off, eight visible bytes
    send_request(OP_COMMIT, 8'hFF);   // empty text shows zeros
    send_request(OP_APPEND, 8'h00);
    send_request(OP_APPEND, 8'hFF);
    send_request(OP_APPEND, 8'hA5);
    send_request(OP_APPEND, 8'h5A);
    send_request(OP_COMMIT, 8'h00);   // short text padded with zeros
    send_request(OP_TICK, 8'hFF);
    send_request(OP_CLEAR, 8'hFF);
    send_request(OP_TICK, 8'h00);     // tick between clear and commit
    send_request(OP_COMMIT, 8'hFF);

    // Directed: one digit, scroll twice, then dwell and return
    apply_setting(1'b1, 1'b0, 0, 0, 0, 1);
    send_request(OP_APPEND, 8'h01);
    send_request(OP_APPEND, 8'h82);
    send_request(OP_APPEND, 8'h43);
    send_request(OP_APPEND, 8'hC4);
    send_request(OP_APPEND, 8'h35);
    send_request(OP_COMMIT, 8'h00);
    repeat (4) send_request(OP_TICK, 8'h00);

    // Directed: same text, wrapping
    apply_setting(1'b1, 1'b1, 0, 0, 0, 1);
    repeat (3) send_request(OP_TICK, 8'hFF);

    // Extreme settings, then random ones
    apply_setting(1'b1, 1'b0, 2, 1, 3, 2);
    run_random(12);
    apply_setting(1'b1, 1'b1, 0, 0, 65535, 0);
    run_random(12);
    apply_setting(1'b1, 1'b0, 65535, 65535, 0, 63);
    run_random(8);
    apply_setting(1'b0, 1'b1, 1, 1, 1, 32);
    run_random(8);
    repeat (4) begin
      apply_setting($urandom_range(1), $urandom_range(1), $urandom_range(0, 8),
                    $urandom_range(0, 5), $urandom_range(0, 8),
                    ($urandom_range(3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8));
      run_random(12);
    end

    // Drain and let any stray bytes show up
    start <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d requests over %0d register settings, %0d window bytes checked",
             n_requests, n_settings, sb.bytes_checked);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- segment_text_scroll_window.f -----
+incdir+design
design/stsw_pkg.sv
design/stsw_ram.sv
design/stsw_regs.sv
design/stsw_ctrl.sv
design/stsw_dp.sv
design/segment_text_scroll_window.sv
verif/tb_segment_text_scroll_window.sv
